>>> hdl/fan_speed_thermal_controller_assert.svh
// Assertion macros used by the checker file.
`ifndef FAN_SPEED_THERMAL_CONTROLLER_ASSERT_SVH
`define FAN_SPEED_THERMAL_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define FSTC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fstc assertion failed");

// Next-cycle implication.
`define FSTC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fstc assertion failed");

`endif

>>> hdl/fstc_pkg.sv
package fstc_pkg;

  localparam logic [6:0] MAX_FAN_SPEED     = 7'd100;
  localparam logic [6:0] PREHEAT_FAN_SPEED = 7'd10;
  localparam logic [6:0] INITIAL_FAN_SPEED = 7'd100;
  localparam logic [1:0] FAIL_LIMIT        = 2'd3;
  localparam int         HISTORY_DEPTH     = 8;
  localparam int         HIST_IDX_W        = $clog2(HISTORY_DEPTH);

  localparam int DIV_W     = 10;
  localparam int DIV_CNT_W = $clog2(DIV_W);

  typedef enum logic [1:0] {
    PROF_NORMAL,
    PROF_OVERHEAT,
    PROF_PREHEAT,
    PROF_FAIL
  } profile_t;

  typedef enum logic [2:0] {
    CFG_TEMP_MIN_VALID,
    CFG_TEMP_MAX_VALID,
    CFG_TEMP_TARGET,
    CFG_TEMP_OVER_THRESHOLD,
    CFG_TEMP_UNDER_THRESHOLD,
    CFG_TEMP_TOLERANCE,
    CFG_PREHEAT_ENABLE,
    CFG_MIN_FAN_SPEED
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_DIV_A,
    S_DIV_B,
    S_STEP,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic agg;
    logic calc;
    logic div_start;
    logic div_sel;
    logic step;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_busy;
  } dp_status_t;

  function automatic logic [6:0] fstc_clamp(logic signed [11:0] s, logic [6:0] lo);
    logic [6:0] r;
    if (s > $signed({5'b0, MAX_FAN_SPEED})) begin
      r = MAX_FAN_SPEED;
    end else if (s < $signed({5'b0, lo})) begin
      r = lo;
    end else begin
      r = s[6:0];
    end
    return r;
  endfunction

endpackage

>>> hdl/fstc_div.sv
module fstc_div
  import fstc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             done
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     rem;
  logic [DIV_W-1:0]     quo;
  logic [DIV_W-1:0]     dvs;
  logic [DIV_W:0]       shifted;
  logic [DIV_W:0]       trial;

  assign shifted  = {rem, quo[DIV_W-1]};
  assign trial    = shifted - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
      end else if (busy) begin
        if (!trial[DIV_W]) begin
          rem <= trial[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b1};
        end else begin
          rem <= shifted[DIV_W-1:0];
          quo <= {quo[DIV_W-2:0], 1'b0};
        end
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/fstc_ctrl.sv
module fstc_ctrl
  import fstc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       last_chain,
  output logic       in_ready,
  output ctrl_cmd_t  cmd,
  input  dp_status_t st
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.agg = 1'b1;
          if (last_chain) begin
            state_next = S_CALC;
          end
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (st.need_div) begin
          cmd.div_start = 1'b1;
          state_next    = S_DIV_A;
        end else begin
          state_next = S_STEP;
        end
      end
      S_DIV_A: begin
        if (st.div_done) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = 1'b1;
          state_next    = S_DIV_B;
        end
      end
      S_DIV_B: begin
        if (st.div_done) begin
          state_next = S_STEP;
        end
      end
      S_STEP: begin
        cmd.step   = 1'b1;
        state_next = S_COMMIT;
      end
      S_COMMIT: begin
        if (!st.out_busy) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/fstc_dp.sv
module fstc_dp
  import fstc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ctrl_cmd_t         cmd,
  output dp_status_t        st,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              chain_enabled,
  input  logic signed [8:0] chain_avg_temp,
  input  logic signed [8:0] chain_high_temp,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        fan_duty,
  output logic              speed_changed,
  output logic [1:0]        profile,
  output logic signed [8:0] device_avg_temp
);

  // configuration
  logic signed [8:0] temp_min_valid;
  logic signed [8:0] temp_max_valid;
  logic signed [8:0] temp_target;
  logic signed [8:0] temp_over_threshold;
  logic signed [8:0] temp_under_threshold;
  logic [5:0]        hyst_tol;
  logic              preheat_enable;
  logic [6:0]        min_fan_speed;

  // state
  logic [6:0]            current_fan_speed;
  logic signed [8:0]     agg_avg_temp;
  logic signed [8:0]     agg_high_temp;
  logic [3:0]            agg_chain_count;
  logic signed [8:0]     prev_avg_temp;
  logic signed [8:0]     prev_high_temp;
  logic [7:0]            rise_history [HISTORY_DEPTH];
  logic [HIST_IDX_W-1:0] rise_write_index;
  logic [1:0]            fail_count;
  logic                  overheat_active;

  // control step registers
  logic              counted;
  logic              ovh;
  logic              pre;
  logic              below;
  logic signed [9:0] rise;
  logic signed [9:0] delta;
  logic signed [11:0] raw_speed;
  logic              do_cmd;

  // combinational
  logic              chain_ok;
  logic signed [8:0] seed_avg;
  logic signed [8:0] seed_high;
  logic              hist_zero;
  logic signed [10:0] avg11;
  logic signed [10:0] high11;
  logic signed [10:0] tol11;
  logic signed [10:0] over_lim;
  logic signed [10:0] under_lim;
  logic signed [10:0] tgt_lim;
  logic signed [9:0] rise_a;
  logic signed [9:0] delta_a;
  logic signed [9:0] rise_h;
  logic signed [9:0] delta_h;
  logic              use_hot;
  logic [1:0]        fail_inc;
  logic              fail_trip;
  logic [DIV_W-1:0]  div_dividend;
  logic [DIV_W-1:0]  div_divisor;
  logic [DIV_W-1:0]  div_quo;
  logic              div_done;
  logic [DIV_W-1:0]  tol_div;
  logic signed [11:0] cur12;
  logic [6:0]        speed_new;
  logic              upd_normal;
  profile_t          prof_new;

  fstc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quo),
    .done     (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_min_valid       <= 9'sd0;
      temp_max_valid       <= 9'sd125;
      temp_target          <= 9'sd75;
      temp_over_threshold  <= 9'sd100;
      temp_under_threshold <= 9'sd30;
      hyst_tol             <= 6'd2;
      preheat_enable       <= 1'b1;
      min_fan_speed        <= 7'd10;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_TEMP_MIN_VALID:       temp_min_valid       <= cfg_data;
        CFG_TEMP_MAX_VALID:       temp_max_valid       <= cfg_data;
        CFG_TEMP_TARGET:          temp_target          <= cfg_data;
        CFG_TEMP_OVER_THRESHOLD:  temp_over_threshold  <= cfg_data;
        CFG_TEMP_UNDER_THRESHOLD: temp_under_threshold <= cfg_data;
        CFG_TEMP_TOLERANCE:       hyst_tol             <= cfg_data[5:0];
        CFG_PREHEAT_ENABLE:       preheat_enable       <= cfg_data[0];
        CFG_MIN_FAN_SPEED:        min_fan_speed        <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    chain_ok  = chain_enabled && (chain_avg_temp > temp_min_valid) &&
                (chain_avg_temp < temp_max_valid);
    seed_avg  = (agg_chain_count != 4'd0) ? agg_avg_temp : 9'sd0;
    seed_high = (agg_chain_count != 4'd0) ? agg_high_temp : temp_min_valid;
    hist_zero = 1'b1;
    for (int i = 0; i < HISTORY_DEPTH; i++) begin
      if (rise_history[i] != 8'd0) begin
        hist_zero = 1'b0;
      end
    end

    avg11     = $signed({{2{agg_avg_temp[8]}}, agg_avg_temp});
    high11    = $signed({{2{agg_high_temp[8]}}, agg_high_temp});
    tol11     = $signed({5'b0, hyst_tol});
    over_lim  = $signed({{2{temp_over_threshold[8]}}, temp_over_threshold}) -
                (overheat_active ? tol11 : 11'sd0);
    under_lim = $signed({{2{temp_under_threshold[8]}}, temp_under_threshold}) - tol11;
    tgt_lim   = $signed({{2{temp_target[8]}}, temp_target}) - tol11;

    rise_a  = $signed({agg_avg_temp[8], agg_avg_temp}) -
              $signed({prev_avg_temp[8], prev_avg_temp});
    delta_a = $signed({agg_avg_temp[8], agg_avg_temp}) -
              $signed({temp_target[8], temp_target});
    rise_h  = $signed({agg_high_temp[8], agg_high_temp}) -
              $signed({prev_high_temp[8], prev_high_temp});
    delta_h = $signed({agg_high_temp[8], agg_high_temp}) -
              $signed({temp_over_threshold[8], temp_over_threshold});
    use_hot = (rise_h > rise_a) || (delta_h > delta_a);

    fail_inc  = (fail_count == 2'd3) ? 2'd3 : fail_count + 2'd1;
    fail_trip = (fail_inc >= FAIL_LIMIT) && (current_fan_speed < MAX_FAN_SPEED);

    tol_div      = (hyst_tol == 6'd0) ? DIV_W'(1) : DIV_W'(hyst_tol);
    div_dividend = cmd.div_sel ? DIV_W'(rise) : DIV_W'(-delta);
    div_divisor  = cmd.div_sel ? div_quo + DIV_W'(1) : tol_div;

    st.need_div = counted && !ovh && !pre && (delta <= 10'sd0) && (rise > 10'sd0);
    st.div_done = div_done;
    st.out_busy = out_valid && !out_ready;

    cur12      = $signed({5'b0, current_fan_speed});
    speed_new  = do_cmd ? fstc_clamp(raw_speed, min_fan_speed) : current_fan_speed;
    upd_normal = counted && !ovh && !pre;
    if (!counted) begin
      prof_new = PROF_FAIL;
    end else if (ovh) begin
      prof_new = PROF_OVERHEAT;
    end else if (pre) begin
      prof_new = PROF_PREHEAT;
    end else begin
      prof_new = PROF_NORMAL;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      counted <= (agg_chain_count != 4'd0);
      ovh     <= high11 >= over_lim;
      pre     <= preheat_enable && (avg11 < under_lim);
      below   <= (avg11 < tgt_lim) || (hist_zero && (agg_avg_temp < temp_target));
      rise    <= use_hot ? rise_h : rise_a;
      delta   <= use_hot ? delta_h : delta_a;
    end
    if (cmd.step) begin
      if (!counted) begin
        raw_speed <= $signed({5'b0, MAX_FAN_SPEED});
        do_cmd    <= fail_trip;
      end else if (ovh) begin
        raw_speed <= $signed({5'b0, MAX_FAN_SPEED});
        do_cmd    <= 1'b1;
      end else if (pre) begin
        raw_speed <= $signed({5'b0, PREHEAT_FAN_SPEED});
        do_cmd    <= 1'b1;
      end else if (delta > 10'sd0) begin
        raw_speed <= cur12 + $signed({{2{delta[9]}}, delta}) +
                     $signed({{2{rise[9]}}, rise});
        do_cmd    <= (rise >= 10'sd0);
      end else begin
        do_cmd <= 1'b1;
        if (rise > 10'sd0) begin
          raw_speed <= cur12 + $signed({2'b0, div_quo});
        end else if (rise == 10'sd0) begin
          raw_speed <= cur12 - $signed({11'b0, below});
        end else begin
          raw_speed <= cur12 + $signed({{2{rise[9]}}, rise});
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_fan_speed <= INITIAL_FAN_SPEED;
      agg_chain_count   <= 4'd0;
      prev_avg_temp     <= 9'sd75;
      prev_high_temp    <= 9'sd0;
      rise_write_index  <= '0;
      fail_count        <= 2'd0;
      overheat_active   <= 1'b0;
      out_valid         <= 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
        rise_history[i] <= 8'd0;
      end
    end else begin
      if (!cmd.commit && out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.agg && chain_ok) begin
        agg_avg_temp  <= (chain_avg_temp > seed_avg) ? chain_avg_temp : seed_avg;
        agg_high_temp <= (chain_high_temp > seed_high) ? chain_high_temp : seed_high;
        if (agg_chain_count != 4'd15) begin
          agg_chain_count <= agg_chain_count + 4'd1;
        end
      end
      if (cmd.commit) begin
        current_fan_speed <= speed_new;
        agg_chain_count   <= 4'd0;
        out_valid         <= 1'b1;
        fan_duty          <= speed_new;
        speed_changed     <= (speed_new != current_fan_speed);
        profile           <= prof_new;
        device_avg_temp   <= counted ? agg_avg_temp : 9'sd0;
        if (counted) begin
          fail_count      <= 2'd0;
          overheat_active <= ovh;
        end else begin
          fail_count <= fail_trip ? 2'd0 : fail_inc;
        end
        if (upd_normal) begin
          prev_avg_temp  <= agg_avg_temp;
          prev_high_temp <= agg_high_temp;
          for (int i = 0; i < HISTORY_DEPTH; i++) begin
            if (HIST_IDX_W'(i) == rise_write_index) begin
              rise_history[i] <= rise[7:0];
            end else if ((delta <= 10'sd0) && (rise == 10'sd0) && below) begin
              rise_history[i] <= 8'hFF;
            end
          end
          rise_write_index <= rise_write_index + 1'b1;
        end
      end
    end
  end

endmodule

>>> hdl/fan_speed_thermal_controller.sv
// Fan speed thermal controller.
// Input channel (in_valid/in_ready): one chain temperature reading per transfer.
// Readings between ticks are folded into a running maximum as they arrive,
// and in_ready stays high for them. The reading with last_chain set closes the
// tick and starts one control step; in_ready is low until that step finishes.
// Output channel (out_valid/out_ready): one result per tick, held in an output
// register. After the closing transfer the control step runs the calc, decide,
// step and commit states; when the below-target scaling needs its two
// divisions, both run in turn on the shared radix-2 divider before step.
// A new tick's readings are taken while the previous result waits; a stalled
// receiver only holds the block at the end of the next control step.
// Configuration: cfg_we writes cfg_data to register cfg_index;
// write only while no tick is in progress.
// Reset (rst, synchronous): registers return to their defaults, fan speed to
// the initial speed, history and counters clear, and no result is pending.
module fan_speed_thermal_controller
  import fstc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              chain_enabled,
  input  logic signed [8:0] chain_avg_temp,
  input  logic signed [8:0] chain_high_temp,
  input  logic              last_chain,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [6:0]        fan_duty,
  output logic              speed_changed,
  output logic [1:0]        profile,
  output logic signed [8:0] device_avg_temp
);

  ctrl_cmd_t  cmd;
  dp_status_t st;

  fstc_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .last_chain (last_chain),
    .in_ready   (in_ready),
    .cmd        (cmd),
    .st         (st)
  );

  fstc_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .chain_enabled   (chain_enabled),
    .chain_avg_temp  (chain_avg_temp),
    .chain_high_temp (chain_high_temp),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .fan_duty        (fan_duty),
    .speed_changed   (speed_changed),
    .profile         (profile),
    .device_avg_temp (device_avg_temp)
  );

endmodule

>>> hdl/fstc_checker.sv
`include "fan_speed_thermal_controller_assert.svh"

module fstc_checker
  import fstc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              last_chain,
  input logic              out_valid,
  input logic              out_ready,
  input logic [6:0]        fan_duty,
  input logic [1:0]        profile,
  input logic signed [8:0] device_avg_temp
);

  `FSTC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(fan_duty) && $stable(profile))
  `FSTC_ASSERT_NEXT(a_tick_closes_input, in_valid && in_ready && last_chain, !in_ready)
  `FSTC_ASSERT_IMPL(a_fail_avg_zero, out_valid && profile == PROF_FAIL, device_avg_temp == 9'sd0)

endmodule

bind fan_speed_thermal_controller fstc_checker u_fstc_checker (.*);

>>> dv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import fstc_pkg::*;

  localparam int FAN_MAX       = MAX_FAN_SPEED;
  localparam int FAN_PREHEAT   = PREHEAT_FAN_SPEED;
  localparam int FAN_START     = INITIAL_FAN_SPEED;
  localparam int FAIL_TRIP     = FAIL_LIMIT;
  localparam int FAIL_SAT      = 3;
  localparam int COUNT_SAT     = 15;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 300;
  localparam int QUIET_LIMIT   = 2000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic              en;
    logic signed [8:0] avg;
    logic signed [8:0] high;
    logic              last;
  } chain_reading_t;

  typedef struct {
    logic [6:0]        speed;
    logic              changed;
    profile_t          prof;
    logic signed [8:0] dev_avg;
  } fan_cmd_t;

  typedef struct {
    logic signed [8:0] min_valid;
    logic signed [8:0] max_valid;
    logic signed [8:0] target;
    logic signed [8:0] over_th;
    logic signed [8:0] under_th;
    logic [5:0]        tol;
    logic              pre_en;
    logic [6:0]        min_speed;
  } fan_settings_t;

  class fan_cmd_scoreboard;
    int min_valid, max_valid, target, over_th, under_th, tol, min_speed;
    bit pre_en;

    int speed, agg_avg, agg_high, chains, prev_avg, prev_high, wr_idx, fails;
    bit overheat;
    logic [7:0] hist [8];

    fan_cmd_t expected_cmds[$];
    int errors, checked, ticks;
    int prof_seen [4];

    function new();
      min_valid = 0;
      max_valid = 125;
      target    = 75;
      over_th   = 100;
      under_th  = 30;
      tol       = 2;
      pre_en    = 1'b1;
      min_speed = 10;
      speed     = FAN_START;
      agg_avg   = 0;
      agg_high  = min_valid;
      chains    = 0;
      prev_avg  = target;
      prev_high = 0;
      wr_idx    = 0;
      fails     = 0;
      overheat  = 1'b0;
      foreach (hist[i]) hist[i] = 8'h00;
    endfunction

    function void write_reg(cfg_idx_t idx, logic [8:0] data);
      case (idx)
        CFG_TEMP_MIN_VALID:       min_valid = $signed(data);
        CFG_TEMP_MAX_VALID:       max_valid = $signed(data);
        CFG_TEMP_TARGET:          target    = $signed(data);
        CFG_TEMP_OVER_THRESHOLD:  over_th   = $signed(data);
        CFG_TEMP_UNDER_THRESHOLD: under_th  = $signed(data);
        CFG_TEMP_TOLERANCE:       tol       = data[5:0];
        CFG_PREHEAT_ENABLE:       pre_en    = data[0];
        CFG_MIN_FAN_SPEED:        min_speed = data[6:0];
        default: ;
      endcase
    endfunction

    function void command_speed(int s);
      if (s > FAN_MAX) begin
        speed = FAN_MAX;
      end else if (s < min_speed) begin
        speed = min_speed;
      end else begin
        speed = s;
      end
    endfunction

    function void note_reading(chain_reading_t r);
      int avg, high, before_speed, tol_oh, rise, delta, hrise, dhi, diff;
      bit all_zero;
      fan_cmd_t cmd;
      avg  = r.avg;
      high = r.high;
      if (r.en && avg > min_valid && avg < max_valid) begin
        if (chains == 0) begin
          agg_avg  = (avg > 0) ? avg : 0;
          agg_high = (high > min_valid) ? high : min_valid;
        end else begin
          agg_avg  = (avg > agg_avg) ? avg : agg_avg;
          agg_high = (high > agg_high) ? high : agg_high;
        end
        if (chains < COUNT_SAT) chains++;
      end
      if (!r.last) return;

      ticks++;
      before_speed = speed;
      cmd.dev_avg  = '0;
      if (chains > 0) begin
        cmd.dev_avg = 9'(agg_avg);
        tol_oh = overheat ? tol : 0;
        if (agg_high >= over_th - tol_oh) begin
          command_speed(FAN_MAX);
          overheat = 1'b1;
          cmd.prof = PROF_OVERHEAT;
        end else begin
          overheat = 1'b0;
          if (pre_en && agg_avg < under_th - tol) begin
            command_speed(FAN_PREHEAT);
            cmd.prof = PROF_PREHEAT;
          end else begin
            cmd.prof = PROF_NORMAL;
            rise  = agg_avg - prev_avg;
            delta = agg_avg - target;
            hrise = agg_high - prev_high;
            dhi   = agg_high - over_th;
            // hot spot wins when it rises faster or sits closer to its limit
            if (hrise > rise || dhi > delta) begin
              rise  = hrise;
              delta = dhi;
            end
            prev_avg  = agg_avg;
            prev_high = agg_high;
            if (delta > 0) begin
              if (rise >= 0) command_speed(speed + delta + rise);
            end else begin
              diff = rise;
              if (rise > 0) begin
                diff = rise / ((-delta) / ((tol != 0) ? tol : 1) + 1);
              end else if (rise == 0) begin
                all_zero = 1'b1;
                foreach (hist[i]) if (hist[i] != 8'h00) all_zero = 1'b0;
                if (agg_avg < target - tol || (all_zero && agg_avg < target)) begin
                  foreach (hist[i]) hist[i] = 8'hFF;
                  diff = -1;
                end
              end
              command_speed(speed + diff);
            end
            hist[wr_idx] = 8'(rise);
            wr_idx = (wr_idx + 1) % 8;
          end
        end
        fails = 0;
      end else begin
        cmd.prof = PROF_FAIL;
        if (fails < FAIL_SAT) fails++;
        if (fails >= FAIL_TRIP && speed < FAN_MAX) begin
          command_speed(FAN_MAX);
          fails = 0;
        end
      end
      chains   = 0;
      agg_avg  = 0;
      agg_high = min_valid;

      cmd.speed   = 7'(speed);
      cmd.changed = (speed != before_speed);
      expected_cmds.push_back(cmd);
    endfunction

    function void check_cmd(fan_cmd_t got);
      fan_cmd_t exp_cmd;
      checked++;
      if (expected_cmds.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] result with nothing pending: speed=%0d profile=%s",
                   $time, got.speed, got.prof.name());
        return;
      end
      exp_cmd = expected_cmds.pop_front();
      prof_seen[exp_cmd.prof]++;
      if (got.speed !== exp_cmd.speed || got.changed !== exp_cmd.changed ||
          got.prof !== exp_cmd.prof || got.dev_avg !== exp_cmd.dev_avg) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("[%0t] mismatch: expected speed=%0d changed=%0b profile=%s avg=%0d",
                   $time, exp_cmd.speed, exp_cmd.changed, exp_cmd.prof.name(),
                   exp_cmd.dev_avg);
          $display("[%0t]           got speed=%0d changed=%0b profile=%s avg=%0d",
                   $time, got.speed, got.changed, got.prof.name(), got.dev_avg);
        end
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [2:0]        cfg_index = '0;
  logic [8:0]        cfg_data = '0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              chain_enabled = 1'b0;
  logic signed [8:0] chain_avg_temp = '0;
  logic signed [8:0] chain_high_temp = '0;
  logic              last_chain = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [6:0]        fan_duty;
  logic              speed_changed;
  logic [1:0]        profile;
  logic signed [8:0] device_avg_temp;

  fan_cmd_scoreboard sb = new();
  fan_settings_t     cur;
  bit                tx_gaps = 1'b0;
  bit                rx_stalls = 1'b1;
  bit                long_hold = 1'b0;
  int                items_sent = 0;
  int                settings_used = 0;
  int                quiet_cycles = 0;

  fan_speed_thermal_controller u_dut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_we) sb.write_reg(cfg_idx_t'(cfg_index), cfg_data);
      if (in_valid && in_ready)
        sb.note_reading('{en: chain_enabled, avg: chain_avg_temp,
                          high: chain_high_temp, last: last_chain});
      if (out_valid && out_ready)
        sb.check_cmd('{speed: fan_duty, changed: speed_changed,
                       prof: profile_t'(profile), dev_avg: device_avg_temp});
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no transfer for %0d cycles", $time, QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // receiver
  initial begin
    int held;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        held = 0;
        while (held < LONG_HOLD) begin
          @(posedge clk);
          held++;
        end
        long_hold = 1'b0;
        out_ready <= 1'b1;
      end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
      @(posedge clk);
    end
  end

  function automatic int clip9(int v);
    return (v > 255) ? 255 : ((v < -256) ? -256 : v);
  endfunction

  function automatic chain_reading_t make_reading(bit dud, bit last);
    chain_reading_t r;
    int lo, hi, a, h;
    lo = cur.min_valid + 1;
    hi = cur.max_valid - 1;
    a  = int'($urandom_range(0, 511)) - 256;
    h  = int'($urandom_range(0, 511)) - 256;
    r.en = 1'b1;
    if (dud) begin
      // disabled, or enabled but outside the valid window
      r.en = ($urandom_range(0, 1) != 0);
      if (r.en) begin
        if ($urandom_range(0, 1) == 1)
          a = cur.min_valid - int'($urandom_range(0, cur.min_valid + 256));
        else
          a = cur.max_valid + int'($urandom_range(0, 255 - cur.max_valid));
      end
    end else if (lo <= hi && $urandom_range(0, 9) != 0) begin
      a = lo + int'($urandom_range(0, hi - lo));
      case ($urandom_range(0, 3))
        0: h = cur.over_th + int'($urandom_range(0, 16)) - 8;
        1: ;
        default: h = a + int'($urandom_range(0, 50)) - 10;
      endcase
    end else begin
      r.en = ($urandom_range(0, 4) != 0);
    end
    r.avg  = 9'(clip9(a));
    r.high = 9'(clip9(h));
    r.last = last;
    return r;
  endfunction

  task automatic send_reading(input chain_reading_t r);
    if (tx_gaps && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    chain_enabled   <= r.en;
    chain_avg_temp  <= r.avg;
    chain_high_temp <= r.high;
    last_chain      <= r.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.expected_cmds.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_idx_t idx, input logic [8:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input fan_settings_t s);
    put_reg(CFG_TEMP_MIN_VALID, s.min_valid);
    put_reg(CFG_TEMP_MAX_VALID, s.max_valid);
    put_reg(CFG_TEMP_TARGET, s.target);
    put_reg(CFG_TEMP_OVER_THRESHOLD, s.over_th);
    put_reg(CFG_TEMP_UNDER_THRESHOLD, s.under_th);
    put_reg(CFG_TEMP_TOLERANCE, {3'b000, s.tol});
    put_reg(CFG_PREHEAT_ENABLE, {8'h00, s.pre_en});
    put_reg(CFG_MIN_FAN_SPEED, {2'b00, s.min_speed});
    cfg_we <= 1'b0;
    cur = s;
    settings_used++;
  endtask

  // mostly whole ticks with random content; repeats drive the steady-state paths,
  // runs of dud ticks drive the read-failure count
  task automatic run_ticks(input int n_items);
    chain_reading_t tick[$];
    int stop_at, nchains, nfail;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) == 0) begin
        nfail = $urandom_range(1, 4);
        repeat (nfail) begin
          nchains = $urandom_range(1, 3);
          for (int i = 0; i < nchains; i++)
            send_reading(make_reading(1'b1, i == nchains - 1));
        end
      end else begin
        if (tick.size() == 0 || $urandom_range(0, 3) != 0) begin
          tick.delete();
          nchains = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
          for (int i = 0; i < nchains; i++)
            tick.push_back(make_reading(1'b0, i == nchains - 1));
        end
        foreach (tick[i]) send_reading(tick[i]);
      end
    end
  endtask

  initial begin
    fan_settings_t plan[$];
    fan_settings_t s;
    int lo, span;

    cur = '{0, 125, 75, 100, 30, 2, 1'b1, 10};
    plan.push_back('{0, 125, 75, 100, 30, 2, 1'b1, 10});
    plan.push_back('{-256, 255, -256, 255, -256, 63, 1'b0, 0});
    plan.push_back('{20, 110, 60, 90, 40, 5, 1'b1, 30});
    plan.push_back('{-100, -10, -50, -20, -60, 1, 1'b1, 100});
    plan.push_back('{0, 150, 70, 120, 20, 0, 1'b1, 5});
    plan.push_back('{10, 200, 255, 160, -256, 63, 1'b1, 50});
    repeat (2) begin
      lo   = int'($urandom_range(0, 316)) - 256;
      span = $urandom_range(20, 190);
      s.min_valid = 9'(lo);
      s.max_valid = 9'(clip9(lo + span));
      s.target    = 9'(clip9(lo + int'($urandom_range(0, span))));
      s.over_th   = 9'(clip9(s.target + int'($urandom_range(0, 60))));
      s.under_th  = 9'(clip9(s.target - int'($urandom_range(0, 60))));
      s.tol       = 6'($urandom_range(1, 63));
      s.pre_en    = ($urandom_range(0, 1) != 0);
      s.min_speed = 7'($urandom_range(0, 100));
      plan.push_back(s);
    end
    plan.push_back('{0, 125, 75, 100, 30, 2, 1'b1, 10});

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed ticks at reset settings
    send_reading('{1, 50, 60, 1});
    send_reading('{1, 50, 60, 1});        // steady below target
    send_reading('{1, -256, 255, 0});     // average at or under the window
    send_reading('{0, 100, 100, 0});
    send_reading('{1, 255, -256, 1});     // nothing counted
    send_reading('{0, 0, 0, 1});
    send_reading('{0, 0, 0, 1});          // third failure forces full speed
    send_reading('{1, 80, 120, 1});       // overheat
    send_reading('{1, 80, 99, 1});        // held by hysteresis
    send_reading('{1, 80, 90, 1});
    send_reading('{1, 78, 70, 1});        // falling above target
    send_reading('{1, 20, 25, 1});        // preheat
    send_reading('{1, 40, 50, 0});
    send_reading('{1, 60, 45, 0});
    send_reading('{1, 1, -256, 0});
    send_reading('{1, 70, -10, 1});
    send_reading('{1, 5, -100, 1});       // lone chain, high seeded from the minimum
    send_reading('{1, 0, 0, 1});          // average equal to the minimum
    send_reading('{1, 124, 0, 1});

    foreach (plan[p]) begin
      drain(1'b1);
      tx_gaps   = (p != plan.size() - 1) && ($urandom_range(0, 3) != 0);
      rx_stalls = (p != plan.size() - 1) && ($urandom_range(0, 3) != 0);
      apply_settings(plan[p]);
      if (p == 2) long_hold = 1'b1;
      if (p == 3) begin
        run_ticks(26);
        drain(1'b0);
        run_ticks(26);
      end else begin
        run_ticks(52);
      end
    end

    drain(1'b1);
    if (sb.expected_cmds.size() != 0) begin
      $display("%0d results never arrived", sb.expected_cmds.size());
      sb.errors += sb.expected_cmds.size();
    end

    $display("Sent %0d readings in %0d ticks across %0d register settings, %0d results checked",
             items_sent, sb.ticks, settings_used, sb.checked);
    $display("Profiles: normal %0d, overheat %0d, preheat %0d, read failure %0d",
             sb.prof_seen[PROF_NORMAL], sb.prof_seen[PROF_OVERHEAT],
             sb.prof_seen[PROF_PREHEAT], sb.prof_seen[PROF_FAIL]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
